/* hdl/modified_utf8_string_hash_length_unit_defines.svh */
// Assertion macros used by the RTL of the modified UTF-8 hash unit.
`ifndef MODIFIED_UTF8_STRING_HASH_LENGTH_UNIT_DEFINES_SVH
`define MODIFIED_UTF8_STRING_HASH_LENGTH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MU8H_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MU8H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mu8h_pkg.sv */
`default_nettype none

package mu8h_pkg;

  localparam int unsigned DefCountBits = 24;

  localparam int unsigned HashW  = 32;
  localparam int unsigned CountW = 24;
  localparam int unsigned CharW  = 16;

  // Continuation bytes still expected in the current sequence.
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  localparam logic [CharW-1:0] MinTwoByte   = 16'h0080;
  localparam logic [CharW-1:0] MinThreeByte = 16'h0800;

  // Per-string decoder state, apart from the character counter.
  typedef struct packed {
    logic [1:0]       pend;
    logic             three;
    logic [CharW-1:0] partial;
    logic [HashW-1:0] hash;
    logic [CharW-1:0] cap_char;
    logic             cap_valid;
    logic             err;
  } dec_state_t;

  typedef struct packed {
    logic [HashW-1:0]  hash;
    logic [CountW-1:0] count;
    logic [CharW-1:0]  ch;
    logic              found;
    logic              status;
  } result_t;

endpackage

`default_nettype wire

/* hdl/mu8h_step.sv */
`default_nettype none

module mu8h_step import mu8h_pkg::*; #(
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  dec_state_t              st_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  input  logic [CountW-1:0]       target_i,
  input  logic [7:0]              byte_i,
  output dec_state_t              st_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic                    finish_o,
  output result_t                 res_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [CharW-1:0]      full_char;
  logic [CharW-1:0]      acc_char;
  logic                  acc;
  logic                  set_err;
  dec_state_t            st_mid;
  logic [COUNT_BITS-1:0] count_mid;
  logic [31:0]           count_ext;

  always_comb begin
    full_char = st_i.partial | {10'd0, byte_i[5:0]};
    acc       = 1'b0;
    acc_char  = '0;
    set_err   = 1'b0;
    finish_o  = 1'b0;
    st_mid    = st_i;
    count_mid = count_i;

    priority if (st_i.err) begin
      finish_o = (byte_i == 8'd0);
    end else if (st_i.pend != PendNone) begin
      priority if (byte_i[7:6] != 2'b10) begin
        set_err  = 1'b1;
        finish_o = (byte_i == 8'd0);
      end else if (st_i.three && st_i.pend == PendTwo) begin
        st_mid.partial = st_i.partial | {4'd0, byte_i[5:0], 6'd0};
        st_mid.pend    = PendOne;
      end else if (st_i.three) begin
        if (full_char < MinThreeByte) begin
          set_err = 1'b1;
        end else begin
          acc      = 1'b1;
          acc_char = full_char;
        end
      end else begin
        // C0 80 is the one overlong form that is allowed; it decodes to NUL.
        if (full_char < MinTwoByte && full_char != '0) begin
          set_err = 1'b1;
        end else begin
          acc      = 1'b1;
          acc_char = full_char;
        end
      end
    end else if (byte_i == 8'd0) begin
      finish_o = 1'b1;
    end else if (!byte_i[7]) begin
      acc      = 1'b1;
      acc_char = {8'd0, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      st_mid.partial = {5'd0, byte_i[4:0], 6'd0};
      st_mid.three   = 1'b0;
      st_mid.pend    = PendOne;
    end else if (byte_i[7:4] == 4'b1110) begin
      st_mid.partial = {byte_i[3:0], 12'd0};
      st_mid.three   = 1'b1;
      st_mid.pend    = PendTwo;
    end else begin
      set_err = 1'b1;
    end

    if (acc || set_err) begin
      st_mid.pend    = PendNone;
      st_mid.three   = 1'b0;
      st_mid.partial = '0;
    end
    if (set_err) begin
      st_mid.err = 1'b1;
    end

    // Character update: hash times 31 plus the character, capture, counting.
    if (acc) begin
      st_mid.hash = (st_i.hash << 5) - st_i.hash + {16'd0, acc_char};
      if (!st_i.cap_valid && 32'(count_i) == 32'(target_i)) begin
        st_mid.cap_char  = acc_char;
        st_mid.cap_valid = 1'b1;
      end
      if (count_i != CountMax) begin
        count_mid = count_i + 1'b1;
      end
    end
  end

  assign count_ext = 32'(count_mid);

  always_comb begin
    res_o.hash   = st_mid.err ? '1 : st_mid.hash;
    res_o.count  = count_ext[CountW-1:0];
    res_o.ch     = st_mid.cap_valid ? st_mid.cap_char : '0;
    res_o.found  = st_mid.cap_valid;
    res_o.status = st_mid.err;
    if (finish_o) begin
      st_o    = '0;
      count_o = '0;
    end else begin
      st_o    = st_mid;
      count_o = count_mid;
    end
  end

endmodule

`default_nettype wire

/* hdl/modified_utf8_string_hash_length_unit.sv */
`default_nettype none

// Decodes a NUL-terminated Java modified UTF-8 string arriving one byte per
// transfer and, at the terminating byte, delivers the string's Java hashCode,
// its character count, the character at target_index and a status flag.
// One byte is taken every clock cycle unless a terminator waits behind an
// untaken result: each byte is held in the input register and decoded there
// by a single combinational step, and the terminator's result is registered in
// the result register, which offers it. That register lets the next string's
// bytes keep flowing while a result waits. target_index is written through its
// own channel, which is always ready; the user must write it only while the
// unit is idle, which the block itself does not enforce.
`include "modified_utf8_string_hash_length_unit_defines.svh"

module modified_utf8_string_hash_length_unit import mu8h_pkg::*; #(
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CountW-1:0]        target_index_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [HashW-1:0]  hash_value_o,
  output logic [CountW-1:0]        char_count_o,
  output logic [CharW-1:0]         indexed_char_o,
  output logic                     index_found_o,
  output logic                     status_o
);

  logic [CountW-1:0]     target_q;
  logic                  in_v_q;
  logic [7:0]            in_byte_q;
  dec_state_t            st_q;
  dec_state_t            st_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_BITS-1:0] count_d;
  logic                  finish;
  result_t               res_d;
  result_t               res_q;
  logic                  out_v_q;
  logic                  out_free;
  logic                  adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= target_index_i;
    end
  end

  mu8h_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .st_i    (st_q),
    .count_i (count_q),
    .target_i(target_q),
    .byte_i  (in_byte_q),
    .st_o    (st_d),
    .count_o (count_d),
    .finish_o(finish),
    .res_o   (res_d)
  );

  // A byte moves on unless it ends a string and the full result slot is not taken.
  assign out_free   = !out_v_q || out_ready_i;
  assign adv        = in_v_q && (!finish || out_free);
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      count_q <= '0;
    end else if (adv) begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && finish) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && finish) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign hash_value_o   = res_q.hash;
  assign char_count_o   = res_q.count;
  assign indexed_char_o = res_q.ch;
  assign index_found_o  = res_q.found;
  assign status_o       = res_q.status;

  `MU8H_ASSERT_NOW(a_err_hash, out_v_q && res_q.status, res_q.hash == '1,
    "error result must carry hash -1")
  `MU8H_ASSERT_NOW(a_char_found, out_v_q && !res_q.found, res_q.ch == '0,
    "indexed character must be zero when not found")
  `MU8H_ASSERT_NOW(a_err_idle, st_q.err, st_q.pend == PendNone && st_q.partial == '0,
    "no sequence may be open after an error")
  `MU8H_ASSERT_NEXT(a_end_clears, adv && finish, count_q == '0 && !st_q.err && out_v_q,
    "string end must clear the state and post a result")

endmodule

`default_nettype wire
